[src/ctp_pkg.sv]
// shared types, constants and step functions of the combined tausworthe generator
package ctp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned SEED_W = 64;
  localparam logic [WORD_W-1:0] RESET_WORD = 32'h408c3c09;

  localparam int unsigned WARMUP_ROUNDS = 10;
  localparam int unsigned WARM_W = $clog2(WARMUP_ROUNDS + 1);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [WORD_W-1:0] MIN_ONE = 32'd2;
  localparam logic [WORD_W-1:0] MIN_TWO = 32'd8;
  localparam logic [WORD_W-1:0] MIN_THREE = 32'd16;
  localparam logic [WORD_W-1:0] MIN_FOUR = 32'd128;

  localparam logic [WORD_W-1:0] MASK_ONE = 32'hFFFFFFFE;
  localparam logic [WORD_W-1:0] MASK_TWO = 32'hFFFFFFF8;
  localparam logic [WORD_W-1:0] MASK_THREE = 32'hFFFFFFF0;
  localparam logic [WORD_W-1:0] MASK_FOUR = 32'hFFFFFF80;

  typedef enum logic [0:0] {
    OP_NEXT = 1'b0,
    OP_SEED = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] folded;
  } cmd_t;

  typedef struct packed {
    logic warming;
    logic cmd_pop;
    logic res_push;
  } back_status_t;

  // ((s & c) << d) ^ (((s << a) ^ s) >> b)
  function automatic logic [WORD_W-1:0] taus_step(
    input logic [WORD_W-1:0] s,
    input int unsigned       a,
    input int unsigned       b,
    input logic [WORD_W-1:0] c,
    input int unsigned       d
  );
    logic [WORD_W-1:0] left_part;
    logic [WORD_W-1:0] right_part;
    left_part = (s & c) << d;
    right_part = ((s << a) ^ s) >> b;
    return left_part ^ right_part;
  endfunction

  function automatic logic [WORD_W-1:0] step_one(input logic [WORD_W-1:0] s);
    return taus_step(s, 6, 13, MASK_ONE, 18);
  endfunction

  function automatic logic [WORD_W-1:0] step_two(input logic [WORD_W-1:0] s);
    return taus_step(s, 2, 27, MASK_TWO, 2);
  endfunction

  function automatic logic [WORD_W-1:0] step_three(input logic [WORD_W-1:0] s);
    return taus_step(s, 13, 21, MASK_THREE, 7);
  endfunction

  function automatic logic [WORD_W-1:0] step_four(input logic [WORD_W-1:0] s);
    return taus_step(s, 3, 12, MASK_FOUR, 13);
  endfunction

  // low 32 bits of (seed >> 32) ^ (seed << 10) ^ seed
  function automatic logic [WORD_W-1:0] fold_seed(input logic [SEED_W-1:0] seed);
    return seed[SEED_W-1:WORD_W] ^ {seed[WORD_W-11:0], 10'b0} ^ seed[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] raise_to_min(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] m
  );
    return (x < m) ? x + m : x;
  endfunction

endpackage

[src/combined_tausworthe_prng_unit.sv]
// top level of the four-component combined tausworthe generator
//
//  channel   handshake        payload                      direction
//  command   push / full      command, seed_value          in
//  result    empty / pop      random_value                 out
//
// a next command takes one step of the back-end step logic and passes the front
// register, command queue and result queue; one word can be delivered every
// cycle when nothing stalls; a reseed holds the back end for one load and ten
// warm-up steps of the shared step logic, one step per cycle, and gives no word
// reset loads all four component words with 0x408c3c09 and empties both queues
// a stalled result side fills the two-entry result queue, then the command
// queue, then the front register, and only then raises full
module combined_tausworthe_prng_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [63:0] seed_value,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] random_value
);
  import ctp_pkg::*;

  // front to command queue
  logic         fifo_push;
  cmd_t         fifo_din;
  logic         fifo_full;

  // command queue to back end
  cmd_t         fifo_dout;
  logic         fifo_empty;
  logic         fifo_pop;
  back_status_t back_status;

  // classify the command and fold the seed
  ctp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .seed_value (seed_value),
    .fifo_push  (fifo_push),
    .fifo_din   (fifo_din),
    .fifo_full  (fifo_full)
  );

  // decouples intake from warm-up and result stalls
  ctp_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fifo_push),
    .din   (fifo_din),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .dout  (fifo_dout),
    .empty (fifo_empty)
  );

  // component state, warm-up sequencing and result words
  ctp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (fifo_dout),
    .cmd_empty    (fifo_empty),
    .cmd_pop      (fifo_pop),
    .empty        (empty),
    .pop          (pop),
    .random_value (random_value),
    .status       (back_status)
  );

  // no command leaves the queue during warm-up
  a_no_pop_warming: assert property (@(posedge clk) disable iff (rst)
    back_status.warming |-> !back_status.cmd_pop)
    else $error("command taken during warm-up");

  // no word is produced during warm-up
  a_no_word_warming: assert property (@(posedge clk) disable iff (rst)
    back_status.warming |-> !back_status.res_push)
    else $error("result word produced during warm-up");

  // the back end only takes a command that is there
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    back_status.cmd_pop |-> !fifo_empty)
    else $error("command queue read while empty");

  // a reseed taken starts warm-up on the next cycle
  a_seed_warms: assert property (@(posedge clk) disable iff (rst)
    (back_status.cmd_pop && fifo_dout.op == OP_SEED) |=> back_status.warming)
    else $error("reseed did not start warm-up");

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!full && empty))
    else $error("queue not idle after reset");

endmodule

[src/ctp_front.sv]
// front stage: takes commands, folds the seed and hands them to the command queue
module ctp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       command,
  input  logic [63:0]                seed_value,
  output logic                       fifo_push,
  output ctp_pkg::cmd_t              fifo_din,
  input  logic                       fifo_full
);
  import ctp_pkg::*;

  logic front_valid;
  logic front_valid_next;
  cmd_t front_cmd;
  logic accept;

  assign full = front_valid & fifo_full;
  assign accept = push & ~full;
  assign fifo_push = front_valid & ~fifo_full;
  assign fifo_din = front_cmd;

  always_comb begin
    front_valid_next = front_valid;
    if (accept) begin
      front_valid_next = 1'b1;
    end else if (fifo_push) begin
      front_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_cmd.op <= command ? OP_SEED : OP_NEXT;
      front_cmd.folded <= fold_seed(seed_value);
    end
  end

endmodule

[src/ctp_cmd_fifo.sv]
// two-entry command queue between front and back
module ctp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ctp_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output ctp_pkg::cmd_t dout,
  output logic          empty
);
  import ctp_pkg::*;

  cmd_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == CNT_W'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign do_push = push & ~full;
  assign do_pop = pop & ~empty;
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

[src/ctp_back.sv]
// back end: component words, step logic, warm-up counter and result queue
module ctp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ctp_pkg::cmd_t         cmd,
  input  logic                  cmd_empty,
  output logic                  cmd_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [31:0]           random_value,
  output ctp_pkg::back_status_t status
);
  import ctp_pkg::*;

  logic [WORD_W-1:0] comp_one;
  logic [WORD_W-1:0] comp_two;
  logic [WORD_W-1:0] comp_three;
  logic [WORD_W-1:0] comp_four;
  logic [WORD_W-1:0] step_one_w;
  logic [WORD_W-1:0] step_two_w;
  logic [WORD_W-1:0] step_three_w;
  logic [WORD_W-1:0] step_four_w;
  logic [WARM_W-1:0] warm_cnt;
  logic              warming;

  logic [WORD_W-1:0] res_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  res_wr;
  logic [PTR_W-1:0]  res_rd;
  logic [CNT_W-1:0]  res_count;
  logic              res_push;
  logic              res_pop;
  logic              res_room;

  assign step_one_w = step_one(comp_one);
  assign step_two_w = step_two(comp_two);
  assign step_three_w = step_three(comp_three);
  assign step_four_w = step_four(comp_four);

  assign warming = (warm_cnt != '0);
  assign empty = (res_count == '0);
  assign res_pop = pop & ~empty;
  // a pop this cycle frees the slot the push lands in
  assign res_room = (res_count != CNT_W'(FIFO_DEPTH)) | res_pop;

  assign cmd_pop = ~cmd_empty & ~warming & ((cmd.op == OP_SEED) | res_room);
  assign res_push = cmd_pop & (cmd.op == OP_NEXT);
  assign random_value = res_mem[res_rd];

  assign status.warming = warming;
  assign status.cmd_pop = cmd_pop;
  assign status.res_push = res_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_one <= RESET_WORD;
      comp_two <= RESET_WORD;
      comp_three <= RESET_WORD;
      comp_four <= RESET_WORD;
      warm_cnt <= '0;
    end else if (warming) begin
      comp_one <= step_one_w;
      comp_two <= step_two_w;
      comp_three <= step_three_w;
      comp_four <= step_four_w;
      warm_cnt <= warm_cnt - WARM_W'(1);
    end else if (cmd_pop) begin
      unique case (cmd.op)
        OP_SEED: begin
          comp_one <= raise_to_min(cmd.folded, MIN_ONE);
          comp_two <= raise_to_min(cmd.folded, MIN_TWO);
          comp_three <= raise_to_min(cmd.folded, MIN_THREE);
          comp_four <= raise_to_min(cmd.folded, MIN_FOUR);
          warm_cnt <= WARM_W'(WARMUP_ROUNDS);
        end
        OP_NEXT: begin
          comp_one <= step_one_w;
          comp_two <= step_two_w;
          comp_three <= step_three_w;
          comp_four <= step_four_w;
        end
        default: begin
          warm_cnt <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr <= '0;
      res_rd <= '0;
      res_count <= '0;
    end else begin
      if (res_push) begin
        res_wr <= res_wr + PTR_W'(1);
      end
      if (res_pop) begin
        res_rd <= res_rd + PTR_W'(1);
      end
      if (res_push && !res_pop) begin
        res_count <= res_count + CNT_W'(1);
      end else if (res_pop && !res_push) begin
        res_count <= res_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wr] <= step_one_w ^ step_two_w ^ step_three_w ^ step_four_w;
    end
  end

endmodule

[verif/tb_combined_tausworthe_prng_unit.sv]
// self-checking testbench of the combined tausworthe generator unit
module tb_combined_tausworthe_prng_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ctp_pkg::*;

  // cycles with no accepted word on either side before the run is given up
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_PRINTED = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        command = OP_NEXT;
  logic [63:0] seed_value = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] random_value;

  // shadow copy of the four component words
  logic [WORD_W-1:0] shadow_one;
  logic [WORD_W-1:0] shadow_two;
  logic [WORD_W-1:0] shadow_three;
  logic [WORD_W-1:0] shadow_four;

  // words the block still owes, oldest first
  logic [WORD_W-1:0] expected_words[$];

  // idling controls, turned off for the full-rate stretch
  bit sender_idle_en = 1'b1;
  bit sink_stall_en = 1'b1;

  int unsigned error_count = 0;
  int unsigned words_checked = 0;
  int unsigned nexts_sent = 0;
  int unsigned seeds_sent = 0;
  int unsigned idle_cycles = 0;

  combined_tausworthe_prng_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .command      (command),
    .seed_value   (seed_value),
    .empty        (empty),
    .pop          (pop),
    .random_value (random_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one tausworthe recurrence on a component word
  function automatic logic [WORD_W-1:0] shift_component(
    input logic [WORD_W-1:0] s,
    input int unsigned       sa,
    input int unsigned       sb,
    input logic [WORD_W-1:0] keep,
    input int unsigned       sd
  );
    logic [WORD_W-1:0] kept;
    logic [WORD_W-1:0] mixed;
    kept = (s & keep) << sd;
    mixed = s << sa;
    mixed = (mixed ^ s) >> sb;
    return kept ^ mixed;
  endfunction

  // steps all four shadow words and returns their xor
  function automatic logic [WORD_W-1:0] shadow_advance();
    shadow_one = shift_component(shadow_one, 6, 13, MASK_ONE, 18);
    shadow_two = shift_component(shadow_two, 2, 27, MASK_TWO, 2);
    shadow_three = shift_component(shadow_three, 13, 21, MASK_THREE, 7);
    shadow_four = shift_component(shadow_four, 3, 12, MASK_FOUR, 13);
    return shadow_one ^ shadow_two ^ shadow_three ^ shadow_four;
  endfunction

  function automatic logic [WORD_W-1:0] lift_floor(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] floor_val
  );
    return (x < floor_val) ? x + floor_val : x;
  endfunction

  // applies one accepted command to the shadow state
  function automatic void shadow_apply(input op_t op, input logic [SEED_W-1:0] seed);
    logic [SEED_W-1:0] mix;
    logic [WORD_W-1:0] folded;
    if (op == OP_SEED) begin
      mix = (seed >> 32) ^ (seed << 10) ^ seed;
      folded = mix[WORD_W-1:0];
      shadow_one = lift_floor(folded, MIN_ONE);
      shadow_two = lift_floor(folded, MIN_TWO);
      shadow_three = lift_floor(folded, MIN_THREE);
      shadow_four = lift_floor(folded, MIN_FOUR);
      // warm-up steps give no word
      for (int r = 0; r < WARMUP_ROUNDS; r++) begin
        void'(shadow_advance());
      end
    end else begin
      expected_words.push_back(shadow_advance());
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    error_count++;
  endtask

  // pushes one command, with a random gap first, and waits until it is taken
  task automatic send_command(input op_t op, input logic [SEED_W-1:0] seed);
    if (sender_idle_en) begin
      while ($urandom_range(99) < 33) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    command <= op;
    seed_value <= seed;
    @(posedge clk);
    // full as seen at the edge decides acceptance
    while (full) @(posedge clk);
    shadow_apply(op, seed);
    if (op == OP_SEED) seeds_sent++;
    else nexts_sent++;
  endtask

  // mostly next words, reseeds now and then, small folded seeds favored
  task automatic send_random_command();
    logic [SEED_W-1:0] seed;
    seed = {$urandom, $urandom};
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(3) == 0) begin
        // upper half alone sets the folded value when the lower half is zero
        seed = {$urandom_range(255), 32'h0};
      end
      send_command(OP_SEED, seed);
    end else begin
      send_command(OP_NEXT, seed);
    end
  endtask

  task automatic wait_for_drain();
    push <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // words straight out of reset, the ignored seed field at both extremes
  task automatic test_reset_state();
    send_command(OP_NEXT, '1);
    send_command(OP_NEXT, '0);
  endtask

  // folded seeds around each component floor, all-ones seed, back-to-back reseeds
  task automatic test_seed_floors();
    logic [WORD_W-1:0] folds[7];
    folds = '{32'd0, 32'd1, 32'd7, 32'd15, 32'd127, 32'd128, 32'hFFFF_FFFF};
    foreach (folds[i]) begin
      send_command(OP_SEED, {folds[i], 32'h0});
      send_command(OP_NEXT, {$urandom, $urandom});
    end
    send_command(OP_SEED, '1);
    send_command(OP_NEXT, '0);
    send_command(OP_SEED, 64'h0000_0000_0000_0001);
    send_command(OP_SEED, 64'h8000_0000_0000_0000);
    send_command(OP_NEXT, '1);
  endtask

  // no idling on either side: a word every cycle except while a reseed warms up
  task automatic test_full_rate(input int unsigned count);
    sender_idle_en = 1'b0;
    sink_stall_en = 1'b0;
    repeat (count) send_random_command();
    sender_idle_en = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  // sender holds off until the block has delivered everything
  task automatic test_drain_pause(input int unsigned count);
    repeat (count) send_random_command();
    wait_for_drain();
    repeat (count / 2) send_random_command();
  endtask

  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_random_command();
  endtask

  // result side: compare each taken word, then pick pop for the next edge
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %08h with none expected", random_value));
        end else begin
          if (random_value !== expected_words[0]) begin
            report_mismatch($sformatf("random_value %08h, expected %08h",
                                      random_value, expected_words[0]));
          end
          void'(expected_words.pop_front());
          words_checked++;
        end
      end
      pop <= sink_stall_en ? ($urandom_range(99) >= 33) : 1'b1;
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles with no progress", idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    shadow_one = RESET_WORD;
    shadow_two = RESET_WORD;
    shadow_three = RESET_WORD;
    shadow_four = RESET_WORD;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_seed_floors();
    test_full_rate(300);
    test_drain_pause(100);
    test_random_mix(1000);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch($sformatf("%0d words never delivered", expected_words.size()));
    end

    $display("sent %0d next commands and %0d reseeds, compared %0d words",
             nexts_sent, seeds_sent, words_checked);
    $display("covered floor seeds, full-rate traffic, a drained pause and random stalls");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/ctp_pkg.sv
src/ctp_front.sv
src/ctp_cmd_fifo.sv
src/ctp_back.sv
src/combined_tausworthe_prng_unit.sv
verif/tb_combined_tausworthe_prng_unit.sv
